FILE: design/circular_2d_convolution_defines.svh
// Assertion macros shared by the circular convolution modules
`ifndef CIRCULAR_2D_CONVOLUTION_DEFINES_SVH
`define CIRCULAR_2D_CONVOLUTION_DEFINES_SVH

// condition holds on every clock edge outside reset
`define CCONV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CCONV_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define CCONV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cconv_pkg.sv
// Shared codes, widths and controller/datapath link types for the circular convolution block
package cconv_pkg;

    localparam logic [1:0] CMD_COEF    = 2'd0;
    localparam logic [1:0] CMD_PIXEL   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_IMAGE_ROWS  = 2'd0;
    localparam logic [1:0] REG_IMAGE_COLS  = 2'd1;
    localparam logic [1:0] REG_KERNEL_ROWS = 2'd2;
    localparam logic [1:0] REG_KERNEL_COLS = 2'd3;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 8;
    localparam int KDIM_W     = 4;
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 33;
    localparam int SUM_W      = 41;
    localparam int DIV_CNT_W  = 3;
    localparam int ADDR_LIMIT = 256;

    typedef struct packed {
        logic accept;
        logic load;
        logic mod_step;
        logic setup;
        logic tap;
        logic out_load;
    } cconv_cmd_t;

    typedef struct packed {
        logic in_range;
        logic mod_last;
        logic last_tap;
        logic pipe_busy;
    } cconv_status_t;

endpackage

FILE: design/circular_2d_convolution.sv
// Top level of the circular 2-D convolution block
//
// Input channel (in_valid/in_ready) carries one word per command: cmd 0 writes a
// kernel coefficient at (row, col), cmd 1 writes an image pixel at (row, col),
// cmd 2 computes the output pixel centred at (row, col) with wrap-around borders.
// Load words are taken without leaving idle and give no result; cmd 3 is dropped.
// Output channel (out_valid/out_ready) returns out_row, out_col and conv_sum
// for each compute word, through an output register.
// A compute word passes through setup, the kernel taps, a pipeline drain and
// the output load before the next word is taken, set by the single
// multiply-accumulate unit reading both stores once per tap; a centre outside
// the image in use first passes through the remainder unit. Configuration
// (cfg_we, cfg_index, cfg_data) is to be written by the user only while the
// block idles; the block does not enforce this. Reset restores 256 x 256 image
// and 3 x 3 kernel sizes and empties the output register; store contents are
// undefined until written. A stalled receiver holds the result; one further
// compute word may finish and then waits until the output register frees.
module circular_2d_convolution
#(
    parameter int MAX_ROWS        = 256,
    parameter int MAX_COLS        = 256,
    parameter int MAX_KERNEL_SIDE = 15
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            cmd,
    input  logic [cconv_pkg::POS_W-1:0]           row,
    input  logic [cconv_pkg::POS_W-1:0]           col,
    input  logic [cconv_pkg::PIX_W-1:0]           pixel_value,
    input  logic signed [cconv_pkg::COEF_W-1:0]   coefficient,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cconv_pkg::POS_W-1:0]           out_row,
    output logic [cconv_pkg::POS_W-1:0]           out_col,
    output logic signed [cconv_pkg::SUM_W-1:0]    conv_sum,
    input  logic                                  cfg_we,
    input  logic [cconv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cconv_pkg::CFG_W-1:0]           cfg_data
);

    cconv_pkg::cconv_cmd_t    ctrl;
    cconv_pkg::cconv_status_t status;

    cconv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    cconv_dp
    #(
        .MAX_ROWS        (MAX_ROWS),
        .MAX_COLS        (MAX_COLS),
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .row         (row),
        .col         (col),
        .pixel_value (pixel_value),
        .coefficient (coefficient),
        .ctrl        (ctrl),
        .status      (status),
        .out_row     (out_row),
        .out_col     (out_col),
        .conv_sum    (conv_sum)
    );

endmodule

FILE: design/cconv_ctrl.sv
// Sequencing state machine and output valid flag for the circular convolution block
`include "circular_2d_convolution_defines.svh"

module cconv_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [1:0]               in_cmd,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  cconv_pkg::cconv_status_t status,
    output cconv_pkg::cconv_cmd_t    ctrl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
                if (in_valid && (in_cmd == cconv_pkg::CMD_COMPUTE))
                begin
                    ctrl.load  = 1'b1;
                    state_next = status.in_range ? ST_SETUP : ST_MOD;
                end
            end
            ST_MOD:
            begin
                ctrl.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                ctrl.setup = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                ctrl.tap = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CCONV_ASSERT_IMPLY(a_no_overwrite, ctrl.out_load, !out_valid_reg || out_ready, "result overwritten before taken")
    `CCONV_ASSERT_NEXT(a_taps_stop, ctrl.tap && status.last_tap, !ctrl.tap, "tap issued past window end")
    `CCONV_ASSERT_NEXT(a_busy_after_load, ctrl.load, !in_ready, "word accepted during compute")

endmodule

FILE: design/cconv_dp.sv
// Configuration registers, stores, wrap-around address unit and multiply-accumulate datapath
`include "circular_2d_convolution_defines.svh"

module cconv_dp
#(
    parameter int MAX_ROWS        = 256,
    parameter int MAX_COLS        = 256,
    parameter int MAX_KERNEL_SIDE = 15
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cconv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cconv_pkg::CFG_W-1:0]           cfg_data,
    input  logic [1:0]                            cmd,
    input  logic [cconv_pkg::POS_W-1:0]           row,
    input  logic [cconv_pkg::POS_W-1:0]           col,
    input  logic [cconv_pkg::PIX_W-1:0]           pixel_value,
    input  logic signed [cconv_pkg::COEF_W-1:0]   coefficient,
    input  cconv_pkg::cconv_cmd_t                 ctrl,
    output cconv_pkg::cconv_status_t              status,
    output logic [cconv_pkg::POS_W-1:0]           out_row,
    output logic [cconv_pkg::POS_W-1:0]           out_col,
    output logic signed [cconv_pkg::SUM_W-1:0]    conv_sum
);

    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW        = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
    localparam int IMG_DEPTH = 2 ** (RW + CW);
    localparam int KER_DEPTH = 2 ** (2 * KW);
    localparam int ROW_LIM   = (MAX_ROWS < cconv_pkg::ADDR_LIMIT) ? MAX_ROWS
                                                                  : cconv_pkg::ADDR_LIMIT;
    localparam int COL_LIM   = (MAX_COLS < cconv_pkg::ADDR_LIMIT) ? MAX_COLS
                                                                  : cconv_pkg::ADDR_LIMIT;

    localparam logic [cconv_pkg::CFG_W-1:0] ROW_LIM_V = cconv_pkg::CFG_W'(ROW_LIM);
    localparam logic [cconv_pkg::CFG_W-1:0] COL_LIM_V = cconv_pkg::CFG_W'(COL_LIM);
    localparam logic [cconv_pkg::CFG_W-1:0] KS_V      = cconv_pkg::CFG_W'(MAX_KERNEL_SIDE);
    localparam logic [12:0]                 MAXR_V    = 13'(MAX_ROWS);
    localparam logic [12:0]                 MAXC_V    = 13'(MAX_COLS);

    localparam int P = cconv_pkg::POS_W;
    localparam int N = cconv_pkg::CFG_W;
    localparam int K = cconv_pkg::KDIM_W;

    logic [N-1:0] image_rows_reg;
    logic [N-1:0] image_cols_reg;
    logic [K-1:0] kernel_rows_reg;
    logic [K-1:0] kernel_cols_reg;

    logic [N-1:0] nr_eff;
    logic [N-1:0] nc_eff;
    logic [N-1:0] kr_lim;
    logic [N-1:0] kc_lim;
    logic [N-1:0] kr_eff;
    logic [N-1:0] kc_eff;
    logic         in_range;

    logic [P-1:0] row_reg;
    logic [P-1:0] col_reg;
    logic [N-1:0] nr_reg;
    logic [N-1:0] nc_reg;
    logic [K-1:0] kr_reg;
    logic [K-1:0] kc_reg;

    logic [P-1:0] rsh_reg;
    logic [P-1:0] csh_reg;
    logic [P-1:0] rem_r_reg;
    logic [P-1:0] rem_c_reg;
    logic [P-1:0] rem_r_next;
    logic [P-1:0] rem_c_next;
    logic [N-1:0] trial_r;
    logic [N-1:0] trial_c;
    logic [cconv_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [K-2:0] hr;
    logic [K-2:0] hc;
    logic [P-1:0] start_r;
    logic [P-1:0] start_c;
    logic [N-1:0] wrap_r_sum;
    logic [N-1:0] wrap_c_sum;

    logic [P-1:0] ir_reg;
    logic [P-1:0] ic_reg;
    logic [P-1:0] ic_start_reg;
    logic [K-1:0] i_reg;
    logic [K-1:0] j_reg;
    logic [N-1:0] ir_inc;
    logic [N-1:0] ic_inc;
    logic [P-1:0] ir_wrap;
    logic [P-1:0] ic_wrap;
    logic         row_end;
    logic [N-1:0] ir_ext;
    logic [N-1:0] ic_ext;

    logic                      pix_ok;
    logic                      coef_ok;
    logic                      img_we;
    logic                      ker_we;
    logic [RW+CW-1:0]          img_wa;
    logic [RW+CW-1:0]          img_ra;
    logic [2*KW-1:0]           ker_wa;
    logic [2*KW-1:0]           ker_ra;
    logic [cconv_pkg::PIX_W-1:0]         img_mem [IMG_DEPTH];
    logic signed [cconv_pkg::COEF_W-1:0] ker_mem [KER_DEPTH];
    logic [cconv_pkg::PIX_W-1:0]         img_rd_reg;
    logic signed [cconv_pkg::COEF_W-1:0] ker_rd_reg;
    logic signed [cconv_pkg::PIX_W:0]    pix_s;

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic signed [cconv_pkg::PROD_W-1:0]  prod_reg;
    logic signed [cconv_pkg::SUM_W-1:0]   acc_reg;

    logic [P-1:0]                         out_row_reg;
    logic [P-1:0]                         out_col_reg;
    logic signed [cconv_pkg::SUM_W-1:0]   sum_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= N'(256);
            image_cols_reg  <= N'(256);
            kernel_rows_reg <= K'(3);
            kernel_cols_reg <= K'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cconv_pkg::REG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                cconv_pkg::REG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                cconv_pkg::REG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[K-1:0];
                cconv_pkg::REG_KERNEL_COLS: kernel_cols_reg <= cfg_data[K-1:0];
                default:                    image_rows_reg  <= image_rows_reg;
            endcase
        end
    end

    // saturate sizes into their legal ranges
    always_comb
    begin
        nr_eff = (image_rows_reg == '0) ? N'(1)
               : ((image_rows_reg > ROW_LIM_V) ? ROW_LIM_V : image_rows_reg);
        nc_eff = (image_cols_reg == '0) ? N'(1)
               : ((image_cols_reg > COL_LIM_V) ? COL_LIM_V : image_cols_reg);
        kr_lim = (KS_V < nr_eff) ? KS_V : nr_eff;
        kc_lim = (KS_V < nc_eff) ? KS_V : nc_eff;
        kr_eff = (kernel_rows_reg == '0) ? N'(1)
               : ((N'(kernel_rows_reg) > kr_lim) ? kr_lim : N'(kernel_rows_reg));
        kc_eff = (kernel_cols_reg == '0) ? N'(1)
               : ((N'(kernel_cols_reg) > kc_lim) ? kc_lim : N'(kernel_cols_reg));
        in_range = (N'(row) < nr_eff) && (N'(col) < nc_eff);
    end

    // restoring remainder, one dividend bit per step
    always_comb
    begin
        trial_r    = {rem_r_reg, rsh_reg[P-1]};
        trial_c    = {rem_c_reg, csh_reg[P-1]};
        rem_r_next = (trial_r >= nr_reg) ? P'(trial_r - nr_reg) : trial_r[P-1:0];
        rem_c_next = (trial_c >= nc_reg) ? P'(trial_c - nc_reg) : trial_c[P-1:0];
    end

    // window origin and wrap-around steps
    always_comb
    begin
        hr         = kr_reg[K-1:1];
        hc         = kc_reg[K-1:1];
        wrap_r_sum = N'(rem_r_reg) + nr_reg - N'(hr);
        wrap_c_sum = N'(rem_c_reg) + nc_reg - N'(hc);
        start_r    = (rem_r_reg >= P'(hr)) ? (rem_r_reg - P'(hr)) : wrap_r_sum[P-1:0];
        start_c    = (rem_c_reg >= P'(hc)) ? (rem_c_reg - P'(hc)) : wrap_c_sum[P-1:0];
        ir_inc     = N'(ir_reg) + N'(1);
        ic_inc     = N'(ic_reg) + N'(1);
        ir_wrap    = (ir_inc == nr_reg) ? '0 : ir_inc[P-1:0];
        ic_wrap    = (ic_inc == nc_reg) ? '0 : ic_inc[P-1:0];
        row_end    = (j_reg == kc_reg - K'(1));
        ir_ext     = N'(ir_reg);
        ic_ext     = N'(ic_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (ctrl.mod_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            row_reg   <= row;
            col_reg   <= col;
            nr_reg    <= nr_eff;
            nc_reg    <= nc_eff;
            kr_reg    <= kr_eff[K-1:0];
            kc_reg    <= kc_eff[K-1:0];
            rsh_reg   <= row;
            csh_reg   <= col;
            rem_r_reg <= in_range ? row : '0;
            rem_c_reg <= in_range ? col : '0;
        end
        else if (ctrl.mod_step)
        begin
            rsh_reg   <= rsh_reg << 1;
            csh_reg   <= csh_reg << 1;
            rem_r_reg <= rem_r_next;
            rem_c_reg <= rem_c_next;
        end

        if (ctrl.setup)
        begin
            ir_reg       <= start_r;
            ic_reg       <= start_c;
            ic_start_reg <= start_c;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else if (ctrl.tap)
        begin
            if (row_end)
            begin
                j_reg  <= '0;
                ic_reg <= ic_start_reg;
                i_reg  <= i_reg + K'(1);
                ir_reg <= ir_wrap;
            end
            else
            begin
                j_reg  <= j_reg + K'(1);
                ic_reg <= ic_wrap;
            end
        end
    end

    // stores
    always_comb
    begin
        pix_ok  = ({5'd0, row} < MAXR_V) && ({5'd0, col} < MAXC_V);
        coef_ok = (N'(row) < KS_V) && (N'(col) < KS_V);
        img_we  = ctrl.accept && (cmd == cconv_pkg::CMD_PIXEL) && pix_ok;
        ker_we  = ctrl.accept && (cmd == cconv_pkg::CMD_COEF) && coef_ok;
        img_wa  = {RW'(row), CW'(col)};
        img_ra  = {RW'(ir_reg), CW'(ic_reg)};
        ker_wa  = {KW'(row), KW'(col)};
        ker_ra  = {KW'(i_reg), KW'(j_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_wa] <= pixel_value;
        end
        if (ctrl.tap)
        begin
            img_rd_reg <= img_mem[img_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ker_we)
        begin
            ker_mem[ker_wa] <= coefficient;
        end
        if (ctrl.tap)
        begin
            ker_rd_reg <= ker_mem[ker_ra];
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.tap;
            v2_reg <= v1_reg;
        end
    end

    assign pix_s = $signed({1'b0, img_rd_reg});

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= pix_s * ker_rd_reg;
        end
        if (ctrl.setup)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + cconv_pkg::SUM_W'(prod_reg);
        end
        if (ctrl.out_load)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            sum_reg     <= acc_reg;
        end
    end

    always_comb
    begin
        status.in_range  = in_range;
        status.mod_last  = (div_cnt_reg == '1);
        status.last_tap  = (i_reg == kr_reg - K'(1)) && row_end;
        status.pipe_busy = v1_reg;
    end

    assign out_row  = out_row_reg;
    assign out_col  = out_col_reg;
    assign conv_sum = sum_reg;

    `CCONV_ASSERT_IMPLY(a_tap_in_image, ctrl.tap, (ir_ext < nr_reg) && (ic_ext < nc_reg), "tap address outside image")
    `CCONV_ASSERT_IMPLY(a_rem_bound, ctrl.mod_step, (N'(rem_r_reg) < nr_reg) && (N'(rem_c_reg) < nc_reg), "remainder out of range")

endmodule
